/* rtl/core/rgr_pkg.sv */
// Package for the rotated glyph rasteriser: direction and register codes, glyph types
// and the built-in 3x5 glyph ROM.
// Depends on nothing; used by rotated_glyph_rasterizer_top.sv.
package rgr_pkg;

	localparam int GLYPH_COUNT = 96;
	localparam int GLYPH_COLS  = 3;
	localparam int GLYPH_ROWS  = 5;
	localparam int GlyphIdxW   = $clog2(GLYPH_COUNT);
	localparam int CfgIdxW     = 1;
	localparam int CfgDataW    = 16;
	localparam int CoordW      = 8;
	localparam int ColorW      = 16;

	localparam logic [CoordW-1:0] CURSOR_STEP = 8'd4;
	localparam logic [6:0]        CHAR_MASK   = 7'h7F;
	localparam logic [6:0]        FIRST_CHAR  = 7'h20;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} text_dir_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TEXT_DIRECTION = 1'b0,
		REG_TEXT_COLOR     = 1'b1
	} cfg_reg_t;

	// One glyph as three columns of five row bits; row 0 is bit 0.
	typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_mask_t;

	// Column 0 sits in bits 23:16, column 2 in bits 7:0.
	localparam logic [23:0] GLYPH_ROM [GLYPH_COUNT] = '{
		24'h000000, 24'h002e00, 24'h060006, 24'h3e143e,
		24'h0c3618, 24'h320826, 24'h142a34, 24'h000600,
		24'h001c22, 24'h221c00, 24'h140814, 24'h081c08,
		24'h406000, 24'h080808, 24'h002000, 24'h601c02,
		24'h3e223e, 24'h243e20, 24'h322a26, 24'h222a3e,
		24'h0e083e, 24'h2e2a3a, 24'h3e2a3a, 24'h023a06,
		24'h3e2a3e, 24'h2e2a3e, 24'h001400, 24'h406400,
		24'h081422, 24'h141414, 24'h221408, 24'h022a06,
		24'h3e222e, 24'h3e0a3e, 24'h3e2a36, 24'h3e2222,
		24'h3e221c, 24'h3e2a22, 24'h3e0a02, 24'h3e223a,
		24'h3e083e, 24'h223e22, 24'h30203e, 24'h3e0836,
		24'h3e2020, 24'h3e043e, 24'h3c081e, 24'h3e223e,
		24'h3e0a0e, 24'h3e227e, 24'h3e0a34, 24'h2e2a3a,
		24'h023e02, 24'h3e203e, 24'h1e201e, 24'h3e103e,
		24'h360836, 24'h063806, 24'h322a26, 24'h003e22,
		24'h021c60, 24'h223e00, 24'h040204, 24'h404040,
		24'h000200, 24'h3e0a3e, 24'h3e2a36, 24'h3e2222,
		24'h3e221c, 24'h3e2a22, 24'h3e0a02, 24'h3e223a,
		24'h3e083e, 24'h223e22, 24'h30203e, 24'h3e0836,
		24'h3e2020, 24'h3e043e, 24'h3c081e, 24'h3e223e,
		24'h3e0a0e, 24'h3e227e, 24'h3e0a34, 24'h2e2a3a,
		24'h023e02, 24'h3e203e, 24'h1e201e, 24'h3e103e,
		24'h360836, 24'h063806, 24'h322a26, 24'h083e22,
		24'h007e00, 24'h223e08, 24'h020604, 24'h000000
	};

	// Looks up a character and keeps only the five drawn rows of each column.
	function automatic glyph_mask_t glyph_lookup(input logic [7:0] code);
		logic [6:0]           c7;
		logic [GlyphIdxW-1:0] idx;
		logic [23:0]          entry;
		glyph_mask_t          m;
		c7 = code[6:0] & CHAR_MASK;
		if (c7 < FIRST_CHAR) begin
			idx = '0;
		end else begin
			idx = GlyphIdxW'(c7 - FIRST_CHAR);
		end
		entry = GLYPH_ROM[idx];
		m[0] = entry[21:17];
		m[1] = entry[13:9];
		m[2] = entry[5:1];
		return m;
	endfunction

endpackage

/* rtl/core/rgr_ifaces.sv */
// Valid/ready channel interfaces of the rotated glyph rasteriser: characters in, pixels out.
// Stand-alone; no package needed.
interface rgr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       run_start;
	logic [7:0] start_x;
	logic [7:0] start_y;

	modport source (output valid, char_code, run_start, start_x, start_y, input ready);
	modport sink   (input valid, char_code, run_start, start_x, start_y, output ready);
endinterface

interface rgr_pixel_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [15:0] pixel_color;
	logic        last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

/* rtl/core/rotated_glyph_rasterizer_top.sv */
// Top level of the rotated glyph rasteriser: cursor and configuration registers, pixel walker, output register.
// Depends on rgr_pkg and the channel interfaces in rgr_ifaces.sv.
//
//   Channel    Direction  Carries                                      Transfer when
//   char_in    in         char_code, run_start, start_x, start_y       valid and ready high
//   pixel_out  out        pixel_x, pixel_y, pixel_color, last_pixel    valid and ready high
//   cfg        in         cfg_we, cfg_index, cfg_data                  cfg_we high
//
// A character gives one pixel for each lit pixel of its glyph, from one to fifteen; a blank glyph
// is absorbed and gives no pixel. The pixel walker emits one lit pixel per cycle while pixel_out
// does not stall it. The first pixel passes through the walker and then the output register.
// Reset clears the cursor to the origin, sets direction down and colour white, and empties
// the walker and the output register. A stall on pixel_out holds the walker; the next
// character is taken in the cycle that the last pixel of the current one leaves the walker.
module rotated_glyph_rasterizer_top
	import rgr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	rgr_char_if.sink            char_in,
	rgr_pixel_if.source         pixel_out
);

	// Configuration registers.
	text_dir_t          dir_q;
	logic [ColorW-1:0]  color_q;

	// Text cursor, advanced at every character transfer.
	logic [CoordW-1:0]  cursor_x_q;
	logic [CoordW-1:0]  cursor_y_q;

	// Pixel walker: the lit pixels still to emit and the cursor the glyph was placed at.
	glyph_mask_t        mask_q;
	logic [CoordW-1:0]  base_x_q;
	logic [CoordW-1:0]  base_y_q;

	// Output register.
	logic               out_valid_q;
	logic [CoordW-1:0]  pix_x_q;
	logic [CoordW-1:0]  pix_y_q;
	logic [ColorW-1:0]  pix_color_q;
	logic               pix_last_q;

	logic               busy;
	logic               emit;
	logic               accept;
	logic [1:0]         sel_col;
	logic [2:0]         sel_row;
	logic [GLYPH_ROWS-1:0] col_bits;
	glyph_mask_t        mask_next;
	logic               last_w;
	logic [CoordW-1:0]  dx;
	logic [CoordW-1:0]  dy;
	logic [CoordW-1:0]  load_x;
	logic [CoordW-1:0]  load_y;

	assign busy   = |mask_q;
	assign emit   = busy && (!out_valid_q || pixel_out.ready);
	assign last_w = (mask_next == '0);

	// A new character enters when the walker is empty or hands off its final pixel now.
	assign char_in.ready = !busy || (emit && last_w);
	assign accept        = char_in.valid && char_in.ready;

	// Column is the outer order, so pick the first column with any pixel left,
	// then the lowest row in it.
	always_comb begin
		if (|mask_q[0]) begin
			sel_col = 2'd0;
		end else if (|mask_q[1]) begin
			sel_col = 2'd1;
		end else begin
			sel_col = 2'd2;
		end
		col_bits = mask_q[sel_col];
		priority if (col_bits[0]) begin
			sel_row = 3'd0;
		end else if (col_bits[1]) begin
			sel_row = 3'd1;
		end else if (col_bits[2]) begin
			sel_row = 3'd2;
		end else if (col_bits[3]) begin
			sel_row = 3'd3;
		end else begin
			sel_row = 3'd4;
		end
		mask_next = mask_q;
		mask_next[sel_col][sel_row] = 1'b0;
	end

	// Rotation of the glyph cell into screen offsets from the cursor.
	always_comb begin
		unique case (dir_q)
			DIR_UP: begin
				dx = CoordW'(sel_row);
				dy = CoordW'(3'd2 - 3'(sel_col));
			end
			DIR_DOWN: begin
				dx = CoordW'(3'd4 - sel_row);
				dy = CoordW'(sel_col);
			end
			DIR_RIGHT: begin
				dx = CoordW'(sel_col);
				dy = CoordW'(sel_row);
			end
			DIR_LEFT: begin
				dx = CoordW'(3'd2 - 3'(sel_col));
				dy = CoordW'(3'd4 - sel_row);
			end
			default: begin
				dx = '0;
				dy = '0;
			end
		endcase
	end

	// The start flag places the cursor before this character is drawn.
	assign load_x = char_in.run_start ? char_in.start_x : cursor_x_q;
	assign load_y = char_in.run_start ? char_in.start_y : cursor_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_DOWN;
			color_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEXT_DIRECTION: dir_q   <= text_dir_t'(cfg_data[1:0]);
				REG_TEXT_COLOR:     color_q <= cfg_data[ColorW-1:0];
				default:            ;
			endcase
		end
	end

	// Cursor advance by one cell, in the direction of writing, wrapping around the 8-bit coordinate range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (accept) begin
			unique case (dir_q)
				DIR_UP: begin
					cursor_x_q <= load_x;
					cursor_y_q <= load_y - CURSOR_STEP;
				end
				DIR_DOWN: begin
					cursor_x_q <= load_x;
					cursor_y_q <= load_y + CURSOR_STEP;
				end
				DIR_RIGHT: begin
					cursor_x_q <= load_x + CURSOR_STEP;
					cursor_y_q <= load_y;
				end
				DIR_LEFT: begin
					cursor_x_q <= load_x - CURSOR_STEP;
					cursor_y_q <= load_y;
				end
				default: begin
					cursor_x_q <= load_x;
					cursor_y_q <= load_y;
				end
			endcase
		end
	end

	// Walker: a blank glyph loads an empty mask and so produces nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (accept) begin
			mask_q <= glyph_lookup(char_in.char_code);
		end else if (emit) begin
			mask_q <= mask_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_x_q <= load_x;
			base_y_q <= load_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pixel_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_x_q     <= base_x_q + dx;
			pix_y_q     <= base_y_q + dy;
			pix_color_q <= color_q;
			pix_last_q  <= last_w;
		end
	end

	assign pixel_out.valid       = out_valid_q;
	assign pixel_out.pixel_x     = pix_x_q;
	assign pixel_out.pixel_y     = pix_y_q;
	assign pixel_out.pixel_color = pix_color_q;
	assign pixel_out.last_pixel  = pix_last_q;

endmodule
